@@ rtl/core/sobel_pkg.sv @@
// shared constants, codes and types of the sobel edge core
package sobel_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 32;
  localparam int GREY_W     = 8;
  localparam int LINE_W     = 2 * GREY_W + PIX_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 11'd480;
  localparam logic [DIM_W-1:0] DIM_MIN      = 11'd3;
  localparam logic [DIM_W-1:0] WIDTH_MAX    = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] HEIGHT_MAX   = DIM_W'(MAX_HEIGHT);

  // x/3 == (x*683)>>11 for every x below 2048
  localparam logic [9:0] DIV3_MUL   = 10'd683;
  localparam int         DIV3_SHIFT = 11;
  localparam logic [7:0] GREY_MAX   = 8'd255;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_READ  = 10'b00_0000_0010,
    S_GRAD  = 10'b00_0000_0100,
    S_SQR   = 10'b00_0000_1000,
    S_SUM   = 10'b00_0001_0000,
    S_ROOT  = 10'b00_0010_0000,
    S_EMIT1 = 10'b00_0100_0000,
    S_EMIT2 = 10'b00_1000_0000,
    S_DRD   = 10'b01_0000_0000,
    S_DEMIT = 10'b10_0000_0000
  } state_t;

  typedef struct packed {
    logic accept_pix;
    logic accept_drain;
    logic rmw;
    logic grad;
    logic square;
    logic sum;
    logic root;
    logic emit1;
    logic emit2;
    logic emit_drain;
  } cmd_t;

  typedef struct packed {
    logic drain_ok;
    logic res1;
    logic res2;
    logic root_last;
    logic out_free;
  } sts_t;

endpackage

@@ rtl/core/sobel_ctrl.sv @@
// sequencing state machine of the sobel edge core
module sobel_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_command,
  output logic              in_ready,
  input  sobel_pkg::sts_t   sts,
  output sobel_pkg::cmd_t   cmd
);

  sobel_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sobel_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      sobel_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_command) begin
            cmd.accept_drain = 1'b1;
            state_nxt = sts.drain_ok ? sobel_pkg::S_DRD : sobel_pkg::S_IDLE;
          end else begin
            cmd.accept_pix = 1'b1;
            state_nxt = sobel_pkg::S_READ;
          end
        end
      end
      sobel_pkg::S_READ: begin
        cmd.rmw = 1'b1;
        state_nxt = sobel_pkg::S_GRAD;
      end
      sobel_pkg::S_GRAD: begin
        cmd.grad = 1'b1;
        state_nxt = sobel_pkg::S_SQR;
      end
      sobel_pkg::S_SQR: begin
        cmd.square = 1'b1;
        state_nxt = sobel_pkg::S_SUM;
      end
      sobel_pkg::S_SUM: begin
        cmd.sum = 1'b1;
        state_nxt = sobel_pkg::S_ROOT;
      end
      sobel_pkg::S_ROOT: begin
        cmd.root = 1'b1;
        if (sts.root_last) begin
          state_nxt = sobel_pkg::S_EMIT1;
        end
      end
      sobel_pkg::S_EMIT1: begin
        if (!sts.res1) begin
          state_nxt = sts.res2 ? sobel_pkg::S_EMIT2 : sobel_pkg::S_IDLE;
        end else if (sts.out_free) begin
          cmd.emit1 = 1'b1;
          state_nxt = sts.res2 ? sobel_pkg::S_EMIT2 : sobel_pkg::S_IDLE;
        end
      end
      sobel_pkg::S_EMIT2: begin
        if (sts.out_free) begin
          cmd.emit2 = 1'b1;
          state_nxt = sobel_pkg::S_IDLE;
        end
      end
      sobel_pkg::S_DRD: begin
        state_nxt = sobel_pkg::S_DEMIT;
      end
      sobel_pkg::S_DEMIT: begin
        if (sts.out_free) begin
          cmd.emit_drain = 1'b1;
          state_nxt = sobel_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sobel_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/core/sobel_dp.sv @@
// datapath: line memory, grey window, gradient, square root and result register
module sobel_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sobel_pkg::cmd_t                 cmd,
  output sobel_pkg::sts_t                 sts,
  input  logic                            cfg_valid,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobel_pkg::DIM_W-1:0]     cfg_data,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic [sobel_pkg::COL_W-1:0]     out_col,
  output logic [sobel_pkg::ROW_W-1:0]     out_row,
  output logic                            out_frame_done
);

  localparam int CW = sobel_pkg::COL_W;
  localparam int RW = sobel_pkg::ROW_W;
  localparam int DW = sobel_pkg::DIM_W;
  localparam int PW = sobel_pkg::PIX_W;
  localparam int GW = sobel_pkg::GREY_W;

  // entry: {grey one row above, grey and pixel of the row that wrote the entry}
  logic [sobel_pkg::LINE_W-1:0] line_mem [0:sobel_pkg::MAX_WIDTH-1];
  logic [sobel_pkg::LINE_W-1:0] rd_q;

  logic [DW-1:0] fwidth_r, fheight_r;
  logic [CW-1:0] col_r, drain_cnt_r;
  logic [RW-1:0] row_r;
  logic          drain_act_r;

  logic [PW-1:0] in_pix_r, pcur_hold_r, res1_pix_r, res2_pix_r;
  logic [GW-1:0] win_r [0:2][0:2];
  logic          res1_r, res2_r, interior_r;
  logic [CW-1:0] res1_col_r, res2_col_r;
  logic [RW-1:0] res1_row_r, res2_row_r;
  logic [11:0]   gx_r, gy_r;
  logic [19:0]   sqx_r, sqy_r;
  logic [20:0]   sum_r;
  logic [7:0]    root_r, sbit_r;

  logic          out_valid_r;
  logic [PW-1:0] out_pix_r;
  logic [CW-1:0] out_col_r;
  logic [RW-1:0] out_row_r;
  logic          out_done_r;

  logic [DW-1:0] w_eff, h_eff;
  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [9:0]    grey_sum;
  logic [19:0]   grey_prod;
  logic [GW-1:0] grey;
  logic [GW-1:0] top, mid;
  logic [9:0]    gx_pos, gx_neg, gy_pos, gy_neg;
  logic [11:0]   ax, ay;
  logic [7:0]    root_try;
  logic [15:0]   root_sq;
  logic [7:0]    mag, inv;
  logic          at_end, drain_last;

  always_comb begin
    if (fwidth_r < sobel_pkg::DIM_MIN) begin
      w_eff = sobel_pkg::DIM_MIN;
    end else if (fwidth_r > sobel_pkg::WIDTH_MAX) begin
      w_eff = sobel_pkg::WIDTH_MAX;
    end else begin
      w_eff = fwidth_r;
    end
    if (fheight_r < sobel_pkg::DIM_MIN) begin
      h_eff = sobel_pkg::DIM_MIN;
    end else if (fheight_r > sobel_pkg::HEIGHT_MAX) begin
      h_eff = sobel_pkg::HEIGHT_MAX;
    end else begin
      h_eff = fheight_r;
    end
  end

  assign w_last    = CW'(w_eff - DW'(1));
  assign h_last    = RW'(h_eff - DW'(1));
  assign grey_sum  = 10'(in_pix_r[31:24]) + 10'(in_pix_r[23:16]) + 10'(in_pix_r[15:8]);
  assign grey_prod = grey_sum * sobel_pkg::DIV3_MUL;
  assign grey      = grey_prod[sobel_pkg::DIV3_SHIFT +: GW];
  assign top       = rd_q[sobel_pkg::LINE_W-1 -: GW];
  assign mid       = rd_q[PW +: GW];
  assign at_end    = (row_r == h_last) && (col_r == w_last);
  assign drain_last = (drain_cnt_r == w_last);

  assign gx_pos = 10'(win_r[0][2]) + {1'b0, win_r[1][2], 1'b0} + 10'(win_r[2][2]);
  assign gx_neg = 10'(win_r[0][0]) + {1'b0, win_r[1][0], 1'b0} + 10'(win_r[2][0]);
  assign gy_pos = 10'(win_r[2][0]) + {1'b0, win_r[2][1], 1'b0} + 10'(win_r[2][2]);
  assign gy_neg = 10'(win_r[0][0]) + {1'b0, win_r[0][1], 1'b0} + 10'(win_r[0][2]);
  assign ax = gx_r[11] ? 12'(-gx_r) : gx_r;
  assign ay = gy_r[11] ? 12'(-gy_r) : gy_r;

  assign root_try = root_r | sbit_r;
  assign root_sq  = root_try * root_try;
  // anything from 65536 up saturates the magnitude
  assign mag = (|sum_r[20:16]) ? sobel_pkg::GREY_MAX : root_r;
  assign inv = sobel_pkg::GREY_MAX - mag;

  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      rd_q <= line_mem[col_r];
    end else if (cmd.accept_drain) begin
      rd_q <= line_mem[drain_cnt_r];
    end
    if (cmd.rmw) begin
      line_mem[col_r] <= {mid, grey, in_pix_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept_pix) begin
      in_pix_r <= {in_red, in_green, in_blue, in_alpha};
    end
    if (cmd.rmw) begin
      for (int k = 0; k < 3; k++) begin
        win_r[k][0] <= win_r[k][1];
        win_r[k][1] <= win_r[k][2];
      end
      win_r[0][2] <= top;
      win_r[1][2] <= mid;
      win_r[2][2] <= grey;
      // the pixel one step back is the previous row's entry the result needs
      res1_pix_r  <= pcur_hold_r;
      pcur_hold_r <= rd_q[PW-1:0];
      res2_pix_r  <= rd_q[PW-1:0];
      res1_r      <= ((col_r != '0) && (row_r != '0)) ||
                     ((col_r == '0) && (row_r >= RW'(2)));
      interior_r  <= (col_r >= CW'(2)) && (row_r >= RW'(2));
      res1_col_r  <= (col_r != '0) ? CW'(col_r - CW'(1)) : w_last;
      res1_row_r  <= (col_r != '0) ? RW'(row_r - RW'(1)) : RW'(row_r - RW'(2));
      res2_r      <= at_end;
      res2_col_r  <= w_last;
      res2_row_r  <= RW'(row_r - RW'(1));
    end
    if (cmd.grad) begin
      gx_r <= 12'(gx_pos) - 12'(gx_neg);
      gy_r <= 12'(gy_pos) - 12'(gy_neg);
    end
    if (cmd.square) begin
      sqx_r <= 20'(ax[9:0] * ax[9:0]);
      sqy_r <= 20'(ay[9:0] * ay[9:0]);
    end
    if (cmd.sum) begin
      sum_r  <= 21'(sqx_r) + 21'(sqy_r);
      root_r <= '0;
      sbit_r <= 8'h80;
    end
    if (cmd.root) begin
      if (root_sq <= sum_r[15:0]) begin
        root_r <= root_try;
      end
      sbit_r <= sbit_r >> 1;
    end
    if (cmd.emit1) begin
      out_pix_r  <= interior_r ? {inv, inv, inv, 8'd0} : res1_pix_r;
      out_col_r  <= res1_col_r;
      out_row_r  <= res1_row_r;
      out_done_r <= 1'b0;
    end else if (cmd.emit2) begin
      out_pix_r  <= res2_pix_r;
      out_col_r  <= res2_col_r;
      out_row_r  <= res2_row_r;
      out_done_r <= 1'b0;
    end else if (cmd.emit_drain) begin
      out_pix_r  <= rd_q[PW-1:0];
      out_col_r  <= drain_cnt_r;
      out_row_r  <= h_last;
      out_done_r <= drain_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwidth_r    <= sobel_pkg::WIDTH_RESET;
      fheight_r   <= sobel_pkg::HEIGHT_RESET;
      col_r       <= '0;
      row_r       <= '0;
      drain_cnt_r <= '0;
      drain_act_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && (cfg_index == sobel_pkg::REG_FRAME_WIDTH ||
                        cfg_index == sobel_pkg::REG_FRAME_HEIGHT)) begin
        if (cfg_index == sobel_pkg::REG_FRAME_WIDTH) begin
          fwidth_r <= cfg_data;
        end else begin
          fheight_r <= cfg_data;
        end
        col_r       <= '0;
        row_r       <= '0;
        drain_cnt_r <= '0;
        drain_act_r <= 1'b0;
      end
      if (cmd.accept_pix) begin
        drain_act_r <= 1'b0;
        drain_cnt_r <= '0;
      end
      if (cmd.accept_drain && !drain_act_r) begin
        drain_act_r <= 1'b0;
      end
      if (cmd.rmw) begin
        if (at_end) begin
          col_r       <= '0;
          row_r       <= '0;
          drain_act_r <= 1'b1;
          drain_cnt_r <= '0;
        end else if (col_r == w_last) begin
          col_r <= '0;
          row_r <= row_r + RW'(1);
        end else begin
          col_r <= col_r + CW'(1);
        end
      end
      if (cmd.emit_drain) begin
        if (drain_last) begin
          drain_act_r <= 1'b0;
          drain_cnt_r <= '0;
        end else begin
          drain_cnt_r <= drain_cnt_r + CW'(1);
        end
      end
      if (cmd.emit1 || cmd.emit2 || cmd.emit_drain) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_comb begin
    sts.drain_ok  = drain_act_r;
    sts.res1      = res1_r;
    sts.res2      = res2_r;
    sts.root_last = sbit_r[0];
    sts.out_free  = !out_valid_r || out_ready;
  end

  assign out_valid      = out_valid_r;
  assign out_red        = out_pix_r[31:24];
  assign out_green      = out_pix_r[23:16];
  assign out_blue       = out_pix_r[15:8];
  assign out_alpha      = out_pix_r[7:0];
  assign out_col        = out_col_r;
  assign out_row        = out_row_r;
  assign out_frame_done = out_done_r;

endmodule

@@ rtl/core/sobel_edge_magnitude_invert_core.sv @@
// top level of the sobel edge core: controller and datapath
//
//   channel  signals                                         direction
//   in       in_valid/in_ready, in_command, in_red..in_alpha  input item
//   out      out_valid/out_ready, out_red..out_alpha,
//            out_col, out_row, out_frame_done                result item
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data         register write
//
// a pixel item goes through the accepting step, read, gradient, squaring and sum, the
// bit-serial square root (one root bit a cycle) and an emit step, with a second emit
// step when it gives two results. a drain item goes through the accepting step, the
// registered line memory read and an emit step; an ignored drain is only accepted.
// reset is synchronous and active low; no clearing pass, no result uses a line entry
// before it is written. a stalled output holds the controller in its emit state.
module sobel_edge_magnitude_invert_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_command,
  input  logic [7:0]                      in_red,
  input  logic [7:0]                      in_green,
  input  logic [7:0]                      in_blue,
  input  logic [7:0]                      in_alpha,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_red,
  output logic [7:0]                      out_green,
  output logic [7:0]                      out_blue,
  output logic [7:0]                      out_alpha,
  output logic [sobel_pkg::COL_W-1:0]     out_col,
  output logic [sobel_pkg::ROW_W-1:0]     out_row,
  output logic                            out_frame_done,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sobel_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sobel_pkg::DIM_W-1:0]     cfg_data
);

  sobel_pkg::cmd_t cmd;
  sobel_pkg::sts_t sts;

  assign cfg_ready = 1'b1;

  sobel_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  sobel_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .in_alpha       (in_alpha),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha),
    .out_col        (out_col),
    .out_row        (out_row),
    .out_frame_done (out_frame_done)
  );

endmodule

@@ rtl/core/sobel_checker.sv @@
// port checker of the sobel edge core and its bind
module sobel_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [7:0]                  out_red,
  input logic [sobel_pkg::COL_W-1:0] out_col,
  input logic                        out_frame_done
);

  // result register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a pixel item keeps the core busy, so no item is taken right after it
  a_pix_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !in_command |=> !in_ready)
    else $error("new item taken right after a pixel item");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_red) && $stable(out_col))
    else $error("stalled result changed");

  // the frame ends on the last column, which is at least two
  a_done_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_frame_done |-> out_col >= sobel_pkg::COL_W'(2))
    else $error("frame end flagged on a low column");

endmodule

bind sobel_edge_magnitude_invert_core sobel_checker u_sobel_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_command     (in_command),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_red        (out_red),
  .out_col        (out_col),
  .out_frame_done (out_frame_done)
);
